// ===== sv/lss_pkg.sv =====
// Package for the LIFO stack with search: command and status codes,
// output field widths and the controller/datapath interface structs.
// No dependencies.
package lss_pkg;

  // Default number of stack entries.
  localparam int unsigned LSS_DEPTH = 16;

  // Fixed widths of the beat fields.
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;     // latch the input beat and clear per-item results
    logic    do_push;     // write the value on top and bump the count
    logic    do_pop;      // remove the top word and issue the new-top read
    logic    do_clear;    // drop all entries
    logic    top_load;    // take the read data as the new top word
    logic    srch_start;  // read entry zero and reset the scan index
    logic    srch_next;   // read the next entry of the scan
    logic    set_found;   // record a search match
    logic    set_status;  // record an error status
    status_t status_code;
    logic    out_load;    // load the result register
  } dp_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;    // latched command of the item in flight
    logic empty;  // count is zero
    logic full;   // count equals the depth
    logic multi;  // count is at least two
    logic hit;    // read data matches the search value
    logic last;   // scan index points at the top entry
  } dp_sts_t;

endpackage

// ===== sv/lss_ctrl.sv =====
// Controller of the LIFO stack: one-hot sequencer over accept, execute,
// top refill, search scan and result hand-off. Depends on lss_pkg.
module lss_ctrl
  import lss_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_ctl_t ctl
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_POPW = 5'b00100,
    S_SRCH = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next-state and command decode.
  always_comb begin
    ctl           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        case (sts.cmd)
          CMD_PUSH: begin
            if (sts.full) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = ST_PUSH_FULL;
            end else begin
              ctl.do_push = 1'b1;
            end
          end
          CMD_POP: begin
            if (sts.empty) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = ST_POP_EMPTY;
            end else begin
              ctl.do_pop = 1'b1;
              if (sts.multi) begin
                state_nxt = S_POPW;
              end
            end
          end
          CMD_SEARCH: begin
            if (!sts.empty) begin
              ctl.srch_start = 1'b1;
              state_nxt      = S_SRCH;
            end
          end
          CMD_CLEAR: begin
            ctl.do_clear = 1'b1;
          end
          default: begin
            ctl.do_clear = 1'b1;
          end
        endcase
      end
      S_POPW: begin
        ctl.top_load = 1'b1;
        state_nxt    = S_FIN;
      end
      S_SRCH: begin
        if (sts.hit) begin
          ctl.set_found = 1'b1;
          state_nxt     = S_FIN;
        end else if (sts.last) begin
          state_nxt = S_FIN;
        end else begin
          ctl.srch_next = 1'b1;
        end
      end
      S_FIN: begin
        // Hand the result over once the output register is free or draining.
        if (!out_valid_r || !out_stall) begin
          ctl.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/lss_dp.sv =====
// Datapath of the LIFO stack: entry memory with registered read, count,
// top-word shadow, search scan index and the result register. Depends on lss_pkg.
module lss_dp
  import lss_pkg::*;
#(
  parameter int unsigned DEPTH = LSS_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [1:0]               in_command,
  input  logic signed [WORD_W-1:0] in_value,
  input  dp_ctl_t                  ctl,
  output dp_sts_t                  sts,
  output logic [1:0]               out_status,
  output logic signed [WORD_W-1:0] out_popped_word,
  output logic                     out_found,
  output logic                     out_is_empty,
  output logic [COUNT_W-1:0]       out_entry_count,
  output logic signed [WORD_W-1:0] out_top_word
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Entry memory and its registered read port.
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;
  logic [AW-1:0]     rd_addr;
  logic [CW-1:0]     count_m2;

  // Item state.
  cmd_t              cmd_r;
  logic [WORD_W-1:0] val_r;
  logic [CW-1:0]     count_r;
  logic [WORD_W-1:0] top_r;
  logic [AW-1:0]     idx_r;
  status_t           status_r;
  logic [WORD_W-1:0] popped_r;
  logic              found_r;

  // Result register.
  logic [1:0]               out_status_r;
  logic signed [WORD_W-1:0] out_popped_word_r;
  logic                     out_found_r;
  logic                     out_is_empty_r;
  logic [COUNT_W-1:0]       out_entry_count_r;
  logic signed [WORD_W-1:0] out_top_word_r;

  // Read address: scan start, scan step, or the entry below the popped top.
  assign count_m2 = count_r - CW'(2);
  always_comb begin
    if (ctl.srch_start) begin
      rd_addr = '0;
    end else if (ctl.srch_next) begin
      rd_addr = idx_r + AW'(1);
    end else begin
      rd_addr = count_m2[AW-1:0];
    end
  end

  // Memory write on push and a read every cycle.
  always_ff @(posedge clk) begin
    if (ctl.do_push) begin
      mem[count_r[AW-1:0]] <= val_r;
    end
    rdata_r <= mem[rd_addr];
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.do_push) begin
      count_r <= count_r + CW'(1);
    end else if (ctl.do_pop) begin
      count_r <= count_r - CW'(1);
    end else if (ctl.do_clear) begin
      count_r <= '0;
    end
  end

  // Item registers, top shadow and scan index.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r    <= cmd_t'(in_command);
      val_r    <= in_value;
      status_r <= ST_DONE;
      popped_r <= '0;
      found_r  <= 1'b0;
    end
    if (ctl.set_status) begin
      status_r <= ctl.status_code;
    end
    if (ctl.set_found) begin
      found_r <= 1'b1;
    end
    if (ctl.do_pop) begin
      popped_r <= top_r;
    end
    if (ctl.do_push) begin
      top_r <= val_r;
    end else if (ctl.top_load) begin
      top_r <= rdata_r;
    end
    if (ctl.srch_start) begin
      idx_r <= '0;
    end else if (ctl.srch_next) begin
      idx_r <= idx_r + AW'(1);
    end
  end

  // Result register load.
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_status_r      <= status_r;
      out_popped_word_r <= popped_r;
      out_found_r       <= found_r;
      out_is_empty_r    <= (count_r == '0);
      out_entry_count_r <= COUNT_W'(count_r);
      out_top_word_r    <= (count_r == '0) ? '0 : top_r;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.cmd   = cmd_r;
    sts.empty = (count_r == '0);
    sts.full  = (count_r == CW'(DEPTH));
    sts.multi = (count_r > CW'(1));
    sts.hit   = (rdata_r == val_r);
    sts.last  = (CW'(idx_r) == (count_r - CW'(1)));
  end

  assign out_status      = out_status_r;
  assign out_popped_word = out_popped_word_r;
  assign out_found       = out_found_r;
  assign out_is_empty    = out_is_empty_r;
  assign out_entry_count = out_entry_count_r;
  assign out_top_word    = out_top_word_r;

endmodule

// ===== sv/lifo_stack_with_search.sv =====
// Top level of the LIFO stack with search: joins the controller and the
// datapath. Depends on lss_pkg, lss_ctrl and lss_dp.
//
//   Channel | Direction | Ports
//   --------+-----------+-------------------------------------------------
//   in      | in        | in_valid, in_stall, in_command, in_value
//   out     | out       | out_valid, out_stall, out_status, out_popped_word,
//           |           | out_found, out_is_empty, out_entry_count,
//           |           | out_top_word
//
// One beat is worked on at a time. Push and clear go from accept through execute
// to the result hand-off; pop also refills the top word from memory when an entry
// is left below it, and search scans one entry per cycle through the single
// memory read port until a hit or the top entry.
// Reset (rst_n low, synchronous) empties the stack; no clearing pass is needed.
// A result held under out_stall does not block the next input beat from being
// accepted and worked on; only the hand-off of its result waits.
module lifo_stack_with_search
  import lss_pkg::*;
#(
  parameter int unsigned DEPTH = LSS_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_command,
  input  logic signed [WORD_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic signed [WORD_W-1:0] out_popped_word,
  output logic                     out_found,
  output logic                     out_is_empty,
  output logic [COUNT_W-1:0]       out_entry_count,
  output logic signed [WORD_W-1:0] out_top_word
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  // Sequencer.
  lss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Storage and result datapath.
  lss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_command),
    .in_value        (in_value),
    .ctl             (ctl),
    .sts             (sts),
    .out_status      (out_status),
    .out_popped_word (out_popped_word),
    .out_found       (out_found),
    .out_is_empty    (out_is_empty),
    .out_entry_count (out_entry_count),
    .out_top_word    (out_top_word)
  );

endmodule

// ===== sv/lss_chk.sv =====
// Port-level checker for the LIFO stack with search, bound to the top level.
// Depends on lss_pkg.
module lss_chk
  import lss_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [1:0]               out_status,
  input logic signed [WORD_W-1:0] out_popped_word,
  input logic                     out_found,
  input logic                     out_is_empty,
  input logic [COUNT_W-1:0]       out_entry_count,
  input logic signed [WORD_W-1:0] out_top_word
);

  // A stalled result beat holds its valid, status, popped word, top word and entry count.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_popped_word) && $stable(out_top_word) && $stable(out_entry_count))
    else $error("result beat changed while stalled");

  // The block works on one beat at a time, so it is busy right after an accept.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on two consecutive cycles");

  // An empty stack reports no entries and a zero top word.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_entry_count == '0 && out_top_word == '0)
    else $error("empty flag disagrees with count or top word");

  // A pop on an empty stack removes nothing and leaves it empty.
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_POP_EMPTY |-> out_is_empty && out_popped_word == '0 &&
      !out_found)
    else $error("bad result for pop on empty stack");

  // A search hit is only reported by a successful search.
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_DONE && out_popped_word == '0 &&
      !out_is_empty)
    else $error("search hit with inconsistent result fields");

endmodule

bind lifo_stack_with_search lss_chk u_lss_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_popped_word (out_popped_word),
  .out_found       (out_found),
  .out_is_empty    (out_is_empty),
  .out_entry_count (out_entry_count),
  .out_top_word    (out_top_word)
);
